// ===== rtl/core/shs_pkg.sv =====
package shs_pkg;
  localparam int MaxElements = 64;
  localparam int IdxW = $clog2(MaxElements);
  localparam int CntW = $clog2(MaxElements + 1);
  localparam int DataW = 32;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
    logic                    keep;
  } fe_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    final_res;
    logic                    overflow;
  } res_item_t;
endpackage

// ===== rtl/core/shell_sorter_unit.sv =====
// Shell sorter: elements arrive one per input transfer and fill a 64-entry
// store; the transfer with last set closes the set, and elements beyond 64
// are dropped with overflow set on every result. The sort uses gaps n/2
// down to 1 with no early exit, so a set of n runs somewhat under n*n
// compare steps (3840 for a full store), each reading two entries, comparing
// them and writing both back when it swaps; results are then read and
// output one at a time. A two-entry queue keeps accepting input while a set
// is sorted and emitted; once it fills, inputs are stalled until the back
// end returns to loading.
module shell_sorter_unit
  import shs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [DataW-1:0] in_value,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DataW-1:0] out_sorted_value,
  output logic                    out_final_res,
  output logic                    out_overflow
);
  logic      q_valid, q_stall;
  fe_item_t  q_item;
  res_item_t res;

  shs_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_value, .in_last,
    .q_valid, .q_stall, .q_item
  );

  shs_back u_back (
    .clk, .rst_n, .q_valid, .q_stall, .q_item,
    .out_valid, .out_stall, .out_item(res)
  );

  assign out_sorted_value = res.value;
  assign out_final_res    = res.final_res;
  assign out_overflow     = res.overflow;
endmodule

// ===== rtl/core/shs_front.sv =====
module shs_front
  import shs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [DataW-1:0] in_value,
  input  logic                    in_last,
  output logic                    q_valid,
  input  logic                    q_stall,
  output fe_item_t                q_item
);
  localparam int QD = 2;
  fe_item_t  q_mem_r [QD];
  logic      wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] fill_r, fill_nxt;
  logic      push, pop;

  assign in_stall = (cnt_r == 2'(QD));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && !q_stall;
  assign q_item   = q_mem_r[rp_r];

  always_comb begin
    wp_nxt   = push ? !wp_r : wp_r;
    rp_nxt   = pop ? !rp_r : rp_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
    fill_nxt = fill_r;
    if (push) begin
      if (in_last) fill_nxt = '0;
      else if (fill_r != CntW'(MaxElements)) fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0; fill_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt; fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r].value <= in_value;
      q_mem_r[wp_r].last  <= in_last;
      q_mem_r[wp_r].keep  <= (fill_r != CntW'(MaxElements));
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(QD))
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(QD)) |-> !push) else $error("push into full queue");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CntW'(MaxElements)) else $error("fill count out of range");
endmodule

// ===== rtl/core/shs_back.sv =====
module shs_back
  import shs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_stall,
  input  fe_item_t  q_item,
  output logic      out_valid,
  input  logic      out_stall,
  output res_item_t out_item
);
  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_JINIT = 7'b0000010,
    S_RDA   = 7'b0000100,
    S_RDB   = 7'b0001000,
    S_CMP   = 7'b0010000,
    S_WRB   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } st_t;

  st_t st_r, st_nxt;
  logic signed [DataW-1:0] mem [MaxElements];
  logic signed [DataW-1:0] rd_r, a_r, a_nxt;
  logic [CntW-1:0] n_r, n_nxt, gap_r, gap_nxt, i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic ovf_r, ovf_nxt;
  logic we;
  logic [IdxW-1:0] wa, ra;
  logic signed [DataW-1:0] wd;
  logic emit_pend_r, emit_pend_nxt;
  logic ov_r, ov_nxt;
  res_item_t ob_r, ob_nxt;

  assign out_valid = ov_r;
  assign out_item  = ob_r;
  assign q_stall   = (st_r != S_LOAD);

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  always_comb begin
    st_nxt = st_r; n_nxt = n_r; gap_nxt = gap_r; i_nxt = i_r; j_nxt = j_r; k_nxt = k_r;
    ovf_nxt = ovf_r; a_nxt = a_r; ov_nxt = ov_r; ob_nxt = ob_r;
    emit_pend_nxt = emit_pend_r;
    we = 1'b0; wa = n_r[IdxW-1:0]; wd = q_item.value; ra = j_r[IdxW-1:0];
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (st_r)
      S_LOAD: begin
        if (q_valid) begin
          if (q_item.keep) begin
            we = 1'b1;
            n_nxt = n_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (q_item.last) begin
            gap_nxt = (q_item.keep ? n_r + 1'b1 : n_r) >> 1;
            i_nxt = gap_nxt;
            k_nxt = '0;
            st_nxt = (gap_nxt == '0) ? S_RDA : S_JINIT;
            emit_pend_nxt = (gap_nxt == '0);
          end
        end
      end
      S_JINIT: begin
        if (i_r >= n_r) begin
          gap_nxt = gap_r >> 1;
          i_nxt = gap_nxt;
          if (gap_nxt == '0) begin
            emit_pend_nxt = 1'b1;
            st_nxt = S_RDA;
          end
        end else begin
          j_nxt = i_r;
          st_nxt = S_RDA;
        end
      end
      S_RDA: begin
        ra = emit_pend_r ? k_r[IdxW-1:0] : j_r[IdxW-1:0];
        st_nxt = emit_pend_r ? S_EMIT : S_RDB;
      end
      S_RDB: begin
        a_nxt = rd_r;
        ra = IdxW'(j_r - gap_r);
        st_nxt = S_CMP;
      end
      S_CMP: begin
        if (a_r < rd_r) begin
          we = 1'b1; wa = j_r[IdxW-1:0]; wd = rd_r;
          st_nxt = S_WRB;
        end else begin
          j_nxt = j_r - gap_r;
          if (j_nxt >= gap_r) st_nxt = S_RDA;
          else begin
            i_nxt = i_r + 1'b1;
            st_nxt = S_JINIT;
          end
        end
      end
      S_WRB: begin
        we = 1'b1; wa = IdxW'(j_r - gap_r); wd = a_r;
        j_nxt = j_r - gap_r;
        if (j_nxt >= gap_r) st_nxt = S_RDA;
        else begin
          i_nxt = i_r + 1'b1;
          st_nxt = S_JINIT;
        end
      end
      S_EMIT: begin
        ra = k_r[IdxW-1:0];
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          ob_nxt.value = rd_r;
          ob_nxt.final_res = (k_r + 1'b1 == n_r);
          ob_nxt.overflow = ovf_r;
          k_nxt = k_r + 1'b1;
          if (k_r + 1'b1 == n_r) begin
            n_nxt = '0; ovf_nxt = 1'b0; emit_pend_nxt = 1'b0;
            st_nxt = S_LOAD;
          end else begin
            st_nxt = S_RDA;
          end
        end
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; n_r <= '0; ovf_r <= 1'b0; ov_r <= 1'b0; emit_pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt; n_r <= n_nxt; ovf_r <= ovf_nxt; ov_r <= ov_nxt;
      emit_pend_r <= emit_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gap_r <= gap_nxt; i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt;
    a_r <= a_nxt; ob_r <= ob_nxt;
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("state not one-hot");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(ob_r))) else $error("result lost");
  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CntW'(MaxElements)) else $error("count out of range");
  a_emit_n: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT) |-> (k_r < n_r)) else $error("emit past count");
endmodule
